### src/assert_macros.svh
// Assertion helpers shared by the RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/lphi_pkg.sv
package lphi_pkg;

  // Sizing defaults
  localparam int MAX_SLOTS_DEF = 1024;
  localparam int KEY_BITS      = 31;

  // Fixed field widths
  localparam int TABLE_SIZE_W = 11;
  localparam int SLOT_W       = 10;
  localparam int PROBES_W     = 11;

  localparam logic [TABLE_SIZE_W-1:0] TABLE_SIZE_RST = TABLE_SIZE_W'(1024);

  // Request transaction
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic                batch_end;
  } req_t;

  // Response transaction
  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [PROBES_W-1:0] probes;
    logic                table_full;
    logic                batch_done;
  } rsp_t;

  // Insert sequencer states
  typedef enum logic [2:0] {
    LPHI_CLEAR,
    LPHI_IDLE,
    LPHI_DIV,
    LPHI_RD,
    LPHI_CHK,
    LPHI_FIN
  } state_t;

endpackage

### src/lphi_ram.sv
module lphi_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### src/lphi_div.sv
module lphi_div
  import lphi_pkg::*;
#(
  parameter int DIV_W = 11,
  parameter int REM_W = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [KEY_BITS-1:0] dividend,
  input  logic [DIV_W-1:0]    divisor,
  output logic                done,
  output logic [REM_W-1:0]    rem
);

  localparam int CNT_W = $clog2(KEY_BITS);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [KEY_BITS-1:0] shreg;
  logic [DIV_W-1:0]    div_q;
  logic [DIV_W-1:0]    part;
  logic [DIV_W-1:0]    part_next;
  logic [DIV_W:0]      trial;

  // Restoring step: bring in one dividend bit, subtract if it fits
  always_comb begin
    trial = {part, shreg[KEY_BITS-1]};
    if (trial >= {1'b0, div_q}) begin
      part_next = DIV_W'(trial - {1'b0, div_q});
    end else begin
      part_next = trial[DIV_W-1:0];
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      cnt   <= CNT_W'(KEY_BITS - 1);
      shreg <= dividend;
      div_q <= divisor;
      part  <= '0;
    end else if (busy) begin
      cnt   <= cnt - 1'b1;
      shreg <= {shreg[KEY_BITS-2:0], 1'b0};
      part  <= part_next;
    end
  end

  // Remainder is below the divisor, so it fits the index width
  assign rem = REM_W'(part);

endmodule

### src/linear_probe_hash_insert.sv
// Channel    | Direction | Handshake              | Payload
// req        | in        | req_valid / req_stall  | req_t (key, batch_end)
// rsp        | out       | rsp_valid / rsp_stall  | rsp_t (slot, probes, table_full, batch_done)
// table_size | in        | table_size_wr_en       | table_size_wr_data
//
// Per insert: a bit-serial modulo (DIV), then a registered occupancy read (RD)
// and a check (CHK) per slot examined, then a hand-off (FIN) to the response
// register. One insert in flight.
// After rst a clearing pass writes every occupancy entry, with req_stall high.
// A new insert may start while the previous response is stalled; its
// completion waits for that response to drain.
`include "assert_macros.svh"

module linear_probe_hash_insert
  import lphi_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  req_t                    req,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  output rsp_t                    rsp,
  input  logic                    table_size_wr_en,
  input  logic [TABLE_SIZE_W-1:0] table_size_wr_data
);

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int SW = $clog2(MAX_SLOTS + 1);

  state_t state;
  state_t state_next;

  logic [TABLE_SIZE_W-1:0] table_size;
  logic [SW-1:0]           eff_size;

  logic [AW-1:0]           clr_addr;
  logic [KEY_BITS-1:0]     key_q;
  logic                    batch_q;
  logic [AW-1:0]           idx;
  logic [AW-1:0]           idx_inc;
  logic [SW-1:0]           probes;
  logic [SW-1:0]           probes_inc;
  logic                    res_full;

  logic                    div_start;
  logic                    div_done;
  logic [AW-1:0]           home;

  logic                    used_we;
  logic [AW-1:0]           used_waddr;
  logic [0:0]              used_wdata;
  logic [0:0]              used_rdata;
  logic                    slot_free;
  logic                    key_we;
  logic [KEY_BITS-1:0]     key_rdata;
  logic                    clr_last;
  logic                    rsp_load;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TABLE_SIZE_RST;
    end else if (table_size_wr_en) begin
      table_size <= table_size_wr_data;
    end
  end

  // Zero means one slot; clamp to the storage depth
  always_comb begin
    if (table_size == '0) begin
      eff_size = SW'(1);
    end else if (32'(table_size) > 32'(MAX_SLOTS)) begin
      eff_size = SW'(MAX_SLOTS);
    end else begin
      eff_size = SW'(table_size);
    end
  end

  // Home slot: key mod size
  lphi_div #(
    .DIV_W (SW),
    .REM_W (AW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (req.key),
    .divisor  (eff_size),
    .done     (div_done),
    .rem      (home)
  );

  // Occupancy bits
  lphi_ram #(
    .WIDTH (1),
    .DEPTH (MAX_SLOTS)
  ) u_used (
    .clk     (clk),
    .wr_en   (used_we),
    .wr_addr (used_waddr),
    .wr_data (used_wdata),
    .rd_addr (idx),
    .rd_data (used_rdata)
  );

  // Stored keys, never read back by this block
  lphi_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (MAX_SLOTS)
  ) u_keys (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (idx),
    .wr_data (key_q),
    .rd_addr (idx),
    .rd_data (key_rdata)
  );

  // Probe arithmetic
  assign slot_free  = (used_rdata == 1'b0);
  assign probes_inc = probes + 1'b1;
  assign idx_inc    = ((SW'(idx) + 1'b1) == eff_size) ? '0 : AW'(idx + 1'b1);
  assign clr_last   = (clr_addr == AW'(MAX_SLOTS - 1));
  assign rsp_load   = (state == LPHI_FIN) && (!rsp_valid || !rsp_stall);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      LPHI_CLEAR: if (clr_last) state_next = LPHI_IDLE;
      LPHI_IDLE:  if (req_valid) state_next = LPHI_DIV;
      LPHI_DIV:   if (div_done) state_next = LPHI_RD;
      LPHI_RD:    state_next = LPHI_CHK;
      LPHI_CHK: begin
        if (slot_free || (probes_inc == eff_size)) begin
          state_next = LPHI_FIN;
        end else begin
          state_next = LPHI_RD;
        end
      end
      LPHI_FIN:   if (rsp_load) state_next = LPHI_IDLE;
      default:    state_next = LPHI_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    req_stall  = 1'b1;
    div_start  = 1'b0;
    used_we    = 1'b0;
    used_waddr = idx;
    used_wdata = 1'b1;
    key_we     = 1'b0;
    unique case (state)
      LPHI_CLEAR: begin
        used_we    = 1'b1;
        used_waddr = clr_addr;
        used_wdata = 1'b0;
      end
      LPHI_IDLE: begin
        req_stall = 1'b0;
        div_start = req_valid;
      end
      LPHI_CHK: begin
        used_we = slot_free;
        key_we  = slot_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LPHI_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == LPHI_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Insert datapath
  always_ff @(posedge clk) begin
    case (state)
      LPHI_IDLE: begin
        key_q   <= req.key;
        batch_q <= req.batch_end;
      end
      LPHI_DIV: begin
        idx      <= home;
        probes   <= '0;
        res_full <= 1'b0;
      end
      LPHI_CHK: begin
        if (!slot_free) begin
          probes <= probes_inc;
          if (probes_inc == eff_size) begin
            idx      <= '0;
            res_full <= 1'b1;
          end else begin
            idx <= idx_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.slot       <= SLOT_W'(idx);
      rsp.probes     <= PROBES_W'(probes);
      rsp.table_full <= res_full;
      rsp.batch_done <= batch_q;
    end
  end

  `ASSERT_IMPL(a_idx_in_range, (state == LPHI_RD) || (state == LPHI_CHK), SW'(idx) < eff_size, "probe index beyond table size")
  `ASSERT_IMPL(a_probes_bound, state == LPHI_CHK, probes < eff_size, "probe count reached size while walking")
  `ASSERT_IMPL(a_full_slot_zero, (state == LPHI_FIN) && res_full, (idx == '0) && (probes == eff_size), "full result malformed")
  `ASSERT_NEXT(a_div_done_in_div, state == LPHI_IDLE, !div_done, "divider finished outside modulo phase")

endmodule

### bench/insert_checker.sv
// Watches the request, response and table size ports of the hash insert block.
// It keeps its own occupancy map and predicts each placement in order.
module insert_checker
  import lphi_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  input  logic                    req_stall,
  input  req_t                    req,
  input  logic                    rsp_valid,
  input  logic                    rsp_stall,
  input  rsp_t                    rsp,
  input  logic                    table_size_wr_en,
  input  logic [TABLE_SIZE_W-1:0] table_size_wr_data,
  output int                      mismatches,
  output int                      pending
);

  logic [TABLE_SIZE_W-1:0] size_reg;
  bit   [MAX_SLOTS-1:0]    occupied;
  rsp_t                    placements_due[$];
  rsp_t                    oldest;

  // Linear probe from the home slot; a full sweep of the active range drops the key
  function automatic rsp_t predict_insert(req_t r);
    int unsigned span;
    int unsigned pos;
    int unsigned passed;
    bit          full;
    rsp_t        p;
    span = 32'(size_reg);
    if (span == 0) span = 1;
    if (span > MAX_SLOTS) span = MAX_SLOTS;
    pos    = 32'(r.key) % span;
    passed = 0;
    full   = 1'b0;
    while (!full && occupied[pos]) begin
      pos = (pos + 1 == span) ? 0 : pos + 1;
      passed++;
      full = (passed == span);
    end
    if (full) pos = 0;
    else occupied[pos] = 1'b1;
    p.slot       = pos[SLOT_W-1:0];
    p.probes     = passed[PROBES_W-1:0];
    p.table_full = full;
    p.batch_done = r.batch_end;
    return p;
  endfunction

  // One response field against its prediction
  task automatic flag_field(string field, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Compare first: a response accepted with a request belongs to an earlier one
  always @(posedge clk) begin
    if (rst) begin
      size_reg = TABLE_SIZE_RST;
      occupied = '0;
      placements_due.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (placements_due.size() == 0) begin
          $display("%0t: response mismatch, expected none, actual slot %0d probes %0d",
                   $time, rsp.slot, rsp.probes);
          mismatches++;
        end else begin
          oldest = placements_due.pop_front();
          flag_field("slot", oldest.slot, rsp.slot);
          flag_field("probes", oldest.probes, rsp.probes);
          flag_field("table_full", oldest.table_full, rsp.table_full);
          flag_field("batch_done", oldest.batch_done, rsp.batch_done);
        end
      end
      if (req_valid && !req_stall) placements_due.push_back(predict_insert(req));
      if (table_size_wr_en) size_reg = table_size_wr_data;
    end
    pending = placements_due.size();
  end

endmodule

### bench/tb_top.sv
// Stimulus and verdict for the linear probing insert block.
// Directed keys first, then phases of random keys at alternating small and growing sizes.
module tb_top;
  import lphi_pkg::*;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    req_valid = 1'b0;
  logic                    req_stall;
  req_t                    req = '0;
  logic                    rsp_valid;
  logic                    rsp_stall = 1'b0;
  rsp_t                    rsp;
  logic                    table_size_wr_en = 1'b0;
  logic [TABLE_SIZE_W-1:0] table_size_wr_data = '0;
  int                      mismatches;
  int                      pending;

  bit noisy = 1'b1;
  bit quiet = 1'b0;
  int stall_left = 0;

  always #5 clk = ~clk;

  linear_probe_hash_insert u_dut (
    .clk                (clk),
    .rst                (rst),
    .req_valid          (req_valid),
    .req_stall          (req_stall),
    .req                (req),
    .rsp_valid          (rsp_valid),
    .rsp_stall          (rsp_stall),
    .rsp                (rsp),
    .table_size_wr_en   (table_size_wr_en),
    .table_size_wr_data (table_size_wr_data)
  );

  insert_checker u_check (
    .clk                (clk),
    .rst                (rst),
    .req_valid          (req_valid),
    .req_stall          (req_stall),
    .req                (req),
    .rsp_valid          (rsp_valid),
    .rsp_stall          (rsp_stall),
    .rsp                (rsp),
    .table_size_wr_en   (table_size_wr_en),
    .table_size_wr_data (table_size_wr_data),
    .mismatches         (mismatches),
    .pending            (pending)
  );

  // Response side back-pressure in random bursts
  always @(negedge clk) begin
    if (quiet || !noisy) begin
      rsp_stall = 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      rsp_stall = 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 3) == 0) begin
      rsp_stall = 1'b1;
      stall_left = $urandom_range(0, 4);
    end else begin
      rsp_stall = 1'b0;
    end
  end

  // Called and returns at a falling edge; valid stays up for a back-to-back transaction
  task automatic push_key(input logic [KEY_BITS-1:0] k, input logic last);
    if (noisy && !quiet && $urandom_range(0, 3) == 0) begin
      req_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    req_valid     = 1'b1;
    req.key       = k;
    req.batch_end = last;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  // Table size changes only once every placement has come back
  task automatic set_size(input logic [TABLE_SIZE_W-1:0] v);
    req_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    table_size_wr_en   = 1'b1;
    table_size_wr_data = v;
    @(negedge clk);
    table_size_wr_en = 1'b0;
  endtask

  function automatic logic [KEY_BITS-1:0] pick_key();
    case ($urandom_range(0, 9)) inside
      0:       return KEY_BITS'(31'h7FFF_FFFF - $urandom_range(0, 3));
      1:       return KEY_BITS'($urandom_range(0, 15));
      [2:3]:   return KEY_BITS'($urandom_range(0, 4095));
      default: return KEY_BITS'($urandom());
    endcase
  endfunction

  initial begin
    int span;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Default size: extremes, a collision, a wrap past the last slot
    push_key(31'd0, 1'b0);
    push_key(31'h7FFF_FFFF, 1'b0);
    push_key(31'd1024, 1'b0);
    push_key(31'd2047, 1'b1);
    push_key(31'h2AAA_AAAA, 1'b0);
    push_key(31'h5555_5555, 1'b1);
    // Size zero acts as one slot, already taken
    set_size(11'd0);
    push_key(31'd5, 1'b0);
    set_size(11'd1);
    push_key(31'd0, 1'b1);
    // Oversize saturates to the full table
    set_size(11'h7FF);
    push_key(31'd3, 1'b0);
    push_key(31'd6143, 1'b0);
    // Shrunk while populated: low slots all taken
    set_size(11'd4);
    push_key(31'd2, 1'b1);
    set_size(11'd8);
    push_key(31'd6, 1'b0);
    push_key(31'd14, 1'b0);
    push_key(31'd22, 1'b1);
    push_key(31'd30, 1'b0);
    set_size(11'd1024);
    push_key(31'd12, 1'b1);
    push_key(31'h4000_0000, 1'b0);

    // Small tables fill quickly and then report full; larger ones open fresh slots
    for (int ph = 0; ph < 16; ph++) begin
      if (ph == 15) span = $urandom_range(1024, 2047);
      else if (ph % 2 == 0) span = $urandom_range(1, 32);
      else span = 128 * ((ph + 1) / 2);
      set_size(span[TABLE_SIZE_W-1:0]);
      noisy = (ph % 4 != 3);
      quiet = (ph == 15);
      for (int n = 0; n < 112; n++)
        push_key(pick_key(), $urandom_range(0, 7) == 0);
    end

    req_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200000000;
    $display("tb: failure");
    $finish;
  end

endmodule
